// ===== hdl/dali_forward_frame_transmitter_top_defines.svh =====
// assertion macros for the checker file
`ifndef DALI_FORWARD_FRAME_TRANSMITTER_TOP_DEFINES_SVH
`define DALI_FORWARD_FRAME_TRANSMITTER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define DALI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define DALI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dali_fwd_pkg.sv =====
package dali_fwd_pkg;

  // frame size default and fixed field widths
  localparam int FRAME_BITS_DEF = 16;
  localparam int DATA_W         = 16;
  localparam int CODE_MAX_W     = 32;
  localparam int IDX_W          = 6;

  // last stop-bit tick count before the frame ends
  localparam logic [IDX_W-1:0] STOP_LAST = IDX_W'(3);

  // operation codes of a request
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result of one request
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic receive_enable;
  } res_t;

endpackage

// ===== hdl/dali_fwd_if.sv =====
// request channel: operation and frame data
interface dali_fwd_req_if;
  import dali_fwd_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [DATA_W-1:0] frame_data;

  modport source (output valid, output operation, output frame_data, input ready);
  modport sink   (input valid, input operation, input frame_data, output ready);
endinterface

// result channel: line state after each request
interface dali_fwd_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;
  logic receive_enable;

  modport source (output valid, output line_level, output busy_res, output frame_done,
                  output receive_enable, input ready);
  modport sink   (input valid, input line_level, input busy_res, input frame_done,
                  input receive_enable, output ready);
endinterface

// ===== hdl/dali_fwd_encoder.sv =====
module dali_fwd_encoder import dali_fwd_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic [DATA_W-1:0]       frame_data_i,
  output logic [2*FRAME_BITS-1:0] code_o
);

  // manchester code: a one goes out low then high, a zero high then low
  always_comb begin
    for (int i = 0; i < FRAME_BITS; i++) begin
      code_o[2*i]   = frame_data_i[i];
      code_o[2*i+1] = ~frame_data_i[i];
    end
  end

endmodule

// ===== hdl/dali_fwd_seq.sv =====
module dali_fwd_seq import dali_fwd_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    operation_i,
  input  logic [2*FRAME_BITS-1:0] code_i,
  input  logic                    idle_level_i,
  output res_t                    res_o
);

  localparam int CodeW = 2 * FRAME_BITS;
  localparam int SelW  = $clog2(CodeW);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(CodeW - 1);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_DATA  = 2'd1,
    PH_STOP  = 2'd2
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CodeW-1:0]   code_q, code_d;
  logic               send_q, send_d;
  logic               line_q, line_d;
  logic               rxen_q, rxen_d;
  logic               done;

  // next state for one request
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    code_d  = code_q;
    send_d  = send_q;
    line_d  = line_q;
    rxen_d  = rxen_q;
    done    = 1'b0;
    if (accept_i) begin
      if (operation_i == OP_SEND) begin
        // new frame bits, sequence position kept
        rxen_d = 1'b0;
        code_d = code_i;
        send_d = 1'b1;
      end else if (send_q) begin
        case (phase_q)
          PH_START: begin
            if (idx_q == '0) begin
              line_d = 1'b0;
              idx_d  = idx_q + IDX_W'(1);
            end else begin
              line_d  = 1'b1;
              phase_d = PH_DATA;
              idx_d   = LastIdx;
            end
          end
          PH_DATA: begin
            // index wraps to all ones past the last half-bit
            if (idx_q <= LastIdx) begin
              line_d = code_q[idx_q[SelW-1:0]];
              idx_d  = idx_q - IDX_W'(1);
            end else begin
              line_d  = idle_level_i;
              phase_d = PH_STOP;
              idx_d   = '0;
            end
          end
          PH_STOP: begin
            if (idx_q == '0) begin
              line_d = idle_level_i;
              idx_d  = IDX_W'(1);
            end else if (idx_q < STOP_LAST) begin
              idx_d = idx_q + IDX_W'(1);
            end else begin
              phase_d = PH_START;
              send_d  = 1'b0;
              idx_d   = '0;
              rxen_d  = 1'b1;
              done    = 1'b1;
            end
          end
          default: begin
            phase_d = PH_START;
            idx_d   = '0;
          end
        endcase
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      idx_q   <= '0;
      code_q  <= '0;
      send_q  <= 1'b0;
      line_q  <= 1'b0;
      rxen_q  <= 1'b1;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      code_q  <= code_d;
      send_q  <= send_d;
      line_q  <= line_d;
      rxen_q  <= rxen_d;
    end
  end

  // result reflects the state after this request
  assign res_o.line_level     = line_d;
  assign res_o.busy_res       = send_d;
  assign res_o.frame_done     = done;
  assign res_o.receive_enable = rxen_d;

endmodule

// ===== hdl/dali_forward_frame_transmitter_top.sv =====
// a result is registered when its request is accepted and is shown in the next cycle
// throughput: one request per cycle while results are not stalled
// a stalled result holds off requests; a new one enters in the cycle it is taken
// reset: line low, not sending, receiver enabled, idle level low
module dali_forward_frame_transmitter_top import dali_fwd_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dali_fwd_req_if.sink     req_if_i,
  dali_fwd_res_if.source   res_if_o,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i
);

  logic                    idle_level_q;
  logic                    accept;
  logic [2*FRAME_BITS-1:0] code;
  res_t                    res_d, res_q;
  logic                    out_valid_q;

  // idle level register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_level_q <= 1'b0;
    end else if (cfg_we_i) begin
      idle_level_q <= cfg_wdata_i;
    end
  end

  // take a request whenever the output register is free or draining
  assign req_if_i.ready = !out_valid_q || res_if_o.ready;
  assign accept         = req_if_i.valid && req_if_i.ready;

  dali_fwd_encoder #(
    .FRAME_BITS (FRAME_BITS)
  ) u_encoder (
    .frame_data_i (req_if_i.frame_data),
    .code_o       (code)
  );

  dali_fwd_seq #(
    .FRAME_BITS (FRAME_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (req_if_i.operation),
    .code_i       (code),
    .idle_level_i (idle_level_q),
    .res_o        (res_d)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (res_if_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_if_o.valid          = out_valid_q;
  assign res_if_o.line_level     = res_q.line_level;
  assign res_if_o.busy_res       = res_q.busy_res;
  assign res_if_o.frame_done     = res_q.frame_done;
  assign res_if_o.receive_enable = res_q.receive_enable;

endmodule

// ===== hdl/dali_fwd_checker.sv =====
`include "dali_forward_frame_transmitter_top_defines.svh"

module dali_fwd_checker import dali_fwd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic operation_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic line_level_i,
  input logic busy_res_i,
  input logic frame_done_i,
  input logic receive_enable_i
);

  // every accepted request yields a result in the next cycle
  `DALI_ASSERT_NEXT(a_req_gives_res, in_valid_i && in_ready_i, out_valid_i,
                    "result missing after request")

  // a send request leaves the block busy, not done and with the receiver disabled
  `DALI_ASSERT_NEXT(a_send_busy,
                    in_valid_i && in_ready_i && (operation_i == OP_SEND),
                    busy_res_i && !frame_done_i && !receive_enable_i,
                    "send request did not start a frame")

  // the receiver is enabled exactly when no frame is going out
  `DALI_ASSERT_IMPL(a_rx_vs_busy, out_valid_i, receive_enable_i != busy_res_i,
                    "receive enable and busy disagree")

  // a stalled result holds
  `DALI_ASSERT_NEXT(a_res_hold, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(line_level_i) && $stable(busy_res_i) &&
                    $stable(frame_done_i) && $stable(receive_enable_i),
                    "stalled result changed")

endmodule

bind dali_forward_frame_transmitter_top dali_fwd_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_if_i.valid),
  .in_ready_i       (req_if_i.ready),
  .operation_i      (req_if_i.operation),
  .out_valid_i      (res_if_o.valid),
  .out_ready_i      (res_if_o.ready),
  .line_level_i     (res_if_o.line_level),
  .busy_res_i       (res_if_o.busy_res),
  .frame_done_i     (res_if_o.frame_done),
  .receive_enable_i (res_if_o.receive_enable)
);
